FILE: hdl/c65eu_pkg.sv
// Package for the 6502 execute unit: opcode group codes and shared types.
// No dependencies.
`default_nettype none
package c65eu_pkg;

  localparam logic [1:0] GRP_CTL = 2'd0;
  localparam logic [1:0] GRP_ALU = 2'd1;
  localparam logic [1:0] GRP_RMW = 2'd2;
  localparam logic [1:0] GRP_ILL = 2'd3;

  localparam logic [7:0] FLAG_RESET = 8'h24;
  localparam logic [7:0] SP_RESET   = 8'hFF;
  localparam logic [7:0] ANE_MAGIC  = 8'hEE;

  typedef struct packed {
    logic [7:0] a;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] s;
    logic [7:0] p;
  } regs_t;

  typedef struct packed {
    logic [7:0]  func;
    logic [7:0]  operand;
    logic [7:0]  address_high;
    logic [15:0] next_pc;
  } in_word_t;

  typedef struct packed {
    logic [7:0]  store_data;
    logic        store_enable;
    logic        push_enable;
    logic [7:0]  accumulator;
    logic [7:0]  index_x;
    logic [7:0]  index_y;
    logic [7:0]  stack_pointer;
    logic [7:0]  status_flags;
    logic        branch_taken;
    logic [15:0] branch_target;
    logic        undefined_op;
  } out_word_t;

endpackage
`default_nettype wire

FILE: hdl/c65eu_if.sv
// Valid/ready channel interface carrying one payload word.
// Depends on nothing; payload type is a parameter.
`default_nettype none
interface c65eu_if #(parameter type payload_t = logic [7:0]);
  logic     valid;
  logic     ready;
  payload_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

FILE: hdl/c65eu_alu.sv
// Combinational execute logic for one opcode against the register file.
// Depends on c65eu_pkg.
`default_nettype none
module c65eu_alu
  import c65eu_pkg::*;
(
  input  wire in_word_t  word,
  input  wire regs_t     cur,
  output regs_t          nxt,
  output out_word_t      res
);

  logic [1:0] cc;
  logic [2:0] bbb, aaa;
  logic [7:0] m, h1, r;
  logic [7:0] wa, wx, wy, ws, wp;
  logic [7:0] sd;
  logic se, pe, taken, undef, sel;
  logic [8:0] sum;
  logic [7:0] addm;

  // adder input and compare helpers
  function automatic logic [7:0] zn(input logic [7:0] p, input logic [7:0] v);
    zn = (p & 8'h7D) | {v[7], 5'b0, (v == 8'h00), 1'b0};
  endfunction

  function automatic logic [16:0] adc(input logic [7:0] a, input logic [7:0] b,
                                     input logic [7:0] p);
    logic [8:0] s;
    logic [7:0] q;
    s = {1'b0, a} + {1'b0, b} + {8'b0, p[0]};
    q = p;
    q[0] = s[8];
    q[6] = ~(a[7] ^ b[7]) & (a[7] ^ s[7]);
    q = zn(q, s[7:0]);
    adc = {s[7:0], q, 1'b0};
  endfunction

  function automatic logic [7:0] cmpf(input logic [7:0] p, input logic [7:0] a,
                                      input logic [7:0] b);
    logic [7:0] q;
    q = p;
    q[0] = (a >= b);
    cmpf = zn(q, a - b);
  endfunction

  // shift by kind: ASL ROL LSR ROR; returns {result, carry}
  function automatic logic [8:0] shf(input logic [1:0] k, input logic [7:0] v,
                                     input logic cin);
    case (k)
      2'd0:    shf = {v[6:0], 1'b0, v[7]};
      2'd1:    shf = {v[6:0], cin, v[7]};
      2'd2:    shf = {1'b0, v[7:1], v[0]};
      default: shf = {cin, v[7:1], v[0]};
    endcase
  endfunction

  logic [16:0] ad;
  logic [8:0] sh;

  always_comb begin
    cc  = word.func[1:0];
    bbb = word.func[4:2];
    aaa = word.func[7:5];
    m   = word.operand;
    h1  = word.address_high + 8'd1;
    wa = cur.a; wx = cur.x; wy = cur.y; ws = cur.s; wp = cur.p;
    sd = 8'h00; se = 1'b0; pe = 1'b0; taken = 1'b0; undef = 1'b0;
    r = 8'h00; sum = 9'h0; addm = 8'h00; ad = '0; sh = '0; sel = 1'b0;
    case (cc)
      GRP_CTL: begin
        if (bbb == 3'd4) begin
          case (aaa[2:1])
            2'd0:    sel = wp[7];
            2'd1:    sel = wp[6];
            2'd2:    sel = wp[0];
            default: sel = wp[1];
          endcase
          taken = (sel == aaa[0]);
        end else if (bbb == 3'd6) begin
          case (aaa)
            3'd0: wp[0] = 1'b0;
            3'd1: wp[0] = 1'b1;
            3'd2: wp[2] = 1'b0;
            3'd3: wp[2] = 1'b1;
            3'd4: begin wa = wy; wp = zn(wp, wa); end
            3'd5: wp[6] = 1'b0;
            3'd6: wp[3] = 1'b0;
            default: wp[3] = 1'b1;
          endcase
        end else if (bbb == 3'd2) begin
          case (aaa)
            3'd0: begin sd = wp | 8'h30; pe = 1'b1; ws = ws - 8'd1; end
            3'd1: begin ws = ws + 8'd1; wp = m | 8'h20; end
            3'd2: begin sd = wa; pe = 1'b1; ws = ws - 8'd1; end
            3'd3: begin ws = ws + 8'd1; wa = m; wp = zn(wp, wa); end
            3'd4: begin wy = wy - 8'd1; wp = zn(wp, wy); end
            3'd5: begin wy = wa; wp = zn(wp, wy); end
            3'd6: begin wy = wy + 8'd1; wp = zn(wp, wy); end
            default: begin wx = wx + 8'd1; wp = zn(wp, wx); end
          endcase
        end else if (aaa == 3'd5) begin
          wy = m; wp = zn(wp, wy);
        end else if (aaa[2:1] == 2'b11) begin
          if (bbb <= 3'd3) wp = cmpf(wp, aaa[0] ? wx : wy, m);
        end else if (aaa == 3'd4) begin
          if (bbb == 3'd7) begin sd = wy & h1; se = 1'b1; end
          else if (bbb != 3'd0) begin sd = wy; se = 1'b1; end
        end else if (aaa == 3'd1) begin
          if (bbb == 3'd1 || bbb == 3'd3)
            wp = (wp & 8'h3D) | (m & 8'hC0) | {6'b0, ((m & wa) == 8'h00), 1'b0};
        end else if (bbb == 3'd0 || (bbb == 3'd3 && aaa >= 3'd2)) begin
          undef = 1'b1;
        end
      end
      GRP_ALU: begin
        if (aaa == 3'd4) begin
          if (bbb != 3'd2) begin sd = wa; se = 1'b1; end
        end else begin
          case (aaa)
            3'd0: begin wa = wa | m; wp = zn(wp, wa); end
            3'd1: begin wa = wa & m; wp = zn(wp, wa); end
            3'd2: begin wa = wa ^ m; wp = zn(wp, wa); end
            3'd3: begin ad = adc(wa, m, wp); wa = ad[16:9]; wp = ad[8:1]; end
            3'd5: begin wa = m; wp = zn(wp, wa); end
            3'd6: wp = cmpf(wp, wa, m);
            default: begin ad = adc(wa, ~m, wp); wa = ad[16:9]; wp = ad[8:1]; end
          endcase
        end
      end
      GRP_RMW: begin
        if (bbb == 3'd4 || (bbb == 3'd0 && !aaa[2])) begin
          undef = 1'b1;
        end else if (bbb == 3'd0) begin
          if (aaa == 3'd5) begin wx = m; wp = zn(wp, wx); end
        end else if (bbb == 3'd6) begin
          if (aaa == 3'd4) ws = wx;
          else if (aaa == 3'd5) begin wx = ws; wp = zn(wp, wx); end
        end else if (bbb == 3'd2) begin
          case (aaa)
            3'd4: begin wa = wx; wp = zn(wp, wa); end
            3'd5: begin wx = wa; wp = zn(wp, wx); end
            3'd6: begin wx = wx - 8'd1; wp = zn(wp, wx); end
            3'd7: ;
            default: begin
              sh = shf(aaa[1:0], wa, wp[0]); wa = sh[8:1]; wp[0] = sh[0];
              wp = zn(wp, wa);
            end
          endcase
        end else begin
          case (aaa)
            3'd4: begin sd = (bbb == 3'd7) ? (wx & h1) : wx; se = 1'b1; end
            3'd5: begin wx = m; wp = zn(wp, wx); end
            3'd6: begin r = m - 8'd1; wp = zn(wp, r); sd = r; se = 1'b1; end
            3'd7: begin r = m + 8'd1; wp = zn(wp, r); sd = r; se = 1'b1; end
            default: begin
              sh = shf(aaa[1:0], m, wp[0]); r = sh[8:1]; wp[0] = sh[0];
              wp = zn(wp, r); sd = r; se = 1'b1;
            end
          endcase
        end
      end
      default: begin
        if (!aaa[2] && bbb == 3'd2) begin
          if (!aaa[1]) begin
            wa = wa & m; wp = zn(wp, wa); wp[0] = wa[7];
          end else if (aaa == 3'd2) begin
            r = wa & m; wp[0] = r[0]; wa = {1'b0, r[7:1]}; wp = zn(wp, wa);
          end else begin
            r = wa & m; wa = {wp[0], r[7:1]}; wp = zn(wp, wa);
            wp[0] = wa[6]; wp[6] = wa[6] ^ wa[5];
          end
        end else if (!aaa[2]) begin
          sh = shf(aaa[1:0], m, wp[0]); r = sh[8:1]; wp[0] = sh[0];
          sd = r; se = 1'b1;
          case (aaa[1:0])
            2'd0: begin wa = wa | r; wp = zn(wp, wa); end
            2'd1: begin wa = wa & r; wp = zn(wp, wa); end
            2'd2: begin wa = wa ^ r; wp = zn(wp, wa); end
            default: begin ad = adc(wa, r, wp); wa = ad[16:9]; wp = ad[8:1]; end
          endcase
        end else if (aaa == 3'd4) begin
          if (bbb == 3'd2) begin wa = (wa | ANE_MAGIC) & wx & m; wp = zn(wp, wa); end
          else if (bbb == 3'd4 || bbb == 3'd7) begin sd = wa & wx & h1; se = 1'b1; end
          else if (bbb == 3'd6) begin ws = wa & wx; sd = ws & h1; se = 1'b1; end
          else begin sd = wa & wx; se = 1'b1; end
        end else if (aaa == 3'd5) begin
          if (bbb == 3'd2) wa = (wa | ANE_MAGIC) & m;
          else if (bbb == 3'd6) begin ws = ws & m; wa = ws; end
          else wa = m;
          wx = wa; wp = zn(wp, wa);
        end else if (aaa == 3'd6) begin
          if (bbb == 3'd2) begin
            r = wa & wx; wp[0] = (r >= m); wx = r - m; wp = zn(wp, wx);
          end else begin
            r = m - 8'd1; sd = r; se = 1'b1; wp = cmpf(wp, wa, r);
          end
        end else begin
          addm = (bbb == 3'd2) ? ~m : ~(m + 8'd1);
          if (bbb != 3'd2) begin sd = m + 8'd1; se = 1'b1; end
          ad = adc(wa, addm, wp); wa = ad[16:9]; wp = ad[8:1];
        end
      end
    endcase
    sum = '0;
    if (undef) begin
      nxt = cur;
      sd = 8'h00; se = 1'b0; pe = 1'b0; taken = 1'b0;
    end else begin
      nxt = '{a: wa, x: wx, y: wy, s: ws, p: wp};
    end
    res.store_data    = sd;
    res.store_enable  = se;
    res.push_enable   = pe;
    res.accumulator   = nxt.a;
    res.index_x       = nxt.x;
    res.index_y       = nxt.y;
    res.stack_pointer = nxt.s;
    res.status_flags  = nxt.p;
    res.branch_taken  = taken;
    res.branch_target = word.next_pc + {{8{m[7]}}, m} + {7'b0, sum};
    res.undefined_op  = undef;
  end

endmodule
`default_nettype wire

FILE: hdl/cpu6502_execute_unit.sv
// 6502 execute stage (binary only), one opcode per word.
// The input register loads at the accept edge, and the result register then
// loads from it once the result stage is free. Throughput: one
// word per cycle; a stalled result holds the input once the input register is full.
// Reset (rst, synchronous): A=X=Y=0, SP=FF, P=24, both stages empty.
// Depends on c65eu_pkg, c65eu_if and c65eu_alu.
`default_nettype none
module cpu6502_execute_unit
  import c65eu_pkg::*;
(
  input wire clk,
  input wire rst,
  c65eu_if.sink   in_ch,
  c65eu_if.source out_ch
);

  // Input stage register; advances whenever the result stage can move.
  logic      in_valid;
  in_word_t  in_word;
  // Architectural registers, updated as each word leaves the execute logic.
  regs_t     regs, regs_next;
  logic      out_valid;
  out_word_t out_word, res_word;
  logic      out_free, in_free;

  // Result register may load when empty or being taken this cycle.
  assign out_free = !out_valid || out_ch.ready;
  // Input register may load when empty or moving on into the result stage.
  assign in_free  = !in_valid || out_free;
  assign in_ch.ready = in_free;

  c65eu_alu u_alu (
    .word (in_word),
    .cur  (regs),
    .nxt  (regs_next),
    .res  (res_word)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
      regs      <= '{a: 8'h00, x: 8'h00, y: 8'h00, s: SP_RESET, p: FLAG_RESET};
    end else begin
      if (in_free) in_valid <= in_ch.valid;
      if (out_free) begin
        out_valid <= in_valid;
        // commit the register file only when a word actually executes
        if (in_valid) regs <= regs_next;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_free && in_ch.valid) in_word <= in_ch.payload;
    if (out_free && in_valid) out_word <= res_word;
  end

  assign out_ch.valid   = out_valid;
  assign out_ch.payload = out_word;

endmodule
`default_nettype wire

FILE: hdl/c65eu_checker.sv
// Port-level checks for the execute unit, bound to the top level.
// Depends on c65eu_pkg.
`default_nettype none
module c65eu_checker
  import c65eu_pkg::*;
(
  input wire            clk,
  input wire            rst,
  input wire            in_valid,
  input wire            in_ready,
  input wire            out_valid,
  input wire            out_ready,
  input wire out_word_t out_payload
);

  a_undef_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_payload.undefined_op |->
      !out_payload.store_enable && !out_payload.push_enable && !out_payload.branch_taken)
    else $error("undefined op with side effect");

  a_one_write: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_payload.store_enable && out_payload.push_enable))
    else $error("store and push together");

  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_payload))
    else $error("output dropped while stalled");

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid)
    else $error("input word withdrawn while stalled");

endmodule

bind cpu6502_execute_unit c65eu_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_payload (out_ch.payload)
);
`default_nettype wire

FILE: test/cpu6502_execute_unit_tb.sv
// Testbench for the 6502 execute unit: drives opcode words, predicts each result word.
// Depends on c65eu_pkg, c65eu_if and the cpu6502_execute_unit RTL.
module cpu6502_execute_unit_tb;
  import c65eu_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;

  logic clk;
  logic rst;

  c65eu_if #(.payload_t(in_word_t))  in_ch();
  c65eu_if #(.payload_t(out_word_t)) out_ch();

  cpu6502_execute_unit uut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch.sink),
    .out_ch(out_ch.source)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Predicted architectural state of the execute unit.
  regs_t cpu_regs;

  out_word_t pending_results[$];
  int        error_count;
  int        idle_cycles;
  int        send_idle_pct;
  int        recv_idle_pct;

  // Scratch state for one instruction.
  logic [7:0] na, nx, ny, ns, np;

  function automatic void upd_zn(logic [7:0] v);
    np[1] = (v == 8'h00);
    np[7] = v[7];
  endfunction

  function automatic logic [7:0] shift_rot(logic [2:0] kind, logic [7:0] m);
    logic [7:0] r;
    logic       cin;
    cin = np[0];
    case (kind)
      3'd0: begin r = {m[6:0], 1'b0}; np[0] = m[7]; end
      3'd1: begin r = {m[6:0], cin};  np[0] = m[7]; end
      3'd2: begin r = {1'b0, m[7:1]}; np[0] = m[0]; end
      default: begin r = {cin, m[7:1]}; np[0] = m[0]; end
    endcase
    return r;
  endfunction

  function automatic void add_carry(logic [7:0] m);
    logic [8:0] s;
    s = {1'b0, na} + {1'b0, m} + {8'h00, np[0]};
    np[0] = s[8];
    np[6] = ~(na[7] ^ m[7]) & (na[7] ^ s[7]);
    na = s[7:0];
    upd_zn(na);
  endfunction

  function automatic void compare(logic [7:0] r, logic [7:0] m);
    np[0] = (r >= m);
    upd_zn(r - m);
  endfunction

  // Execute one opcode against the predicted state and return the result word.
  function automatic out_word_t execute_opcode(in_word_t w);
    out_word_t  o;
    logic [1:0] cc;
    logic [2:0] bbb, aaa;
    logic [7:0] m, h1, r, sd;
    logic       se, pe, taken, undef, flag_set;
    cc = w.func[1:0];
    bbb = w.func[4:2];
    aaa = w.func[7:5];
    m = w.operand;
    h1 = w.address_high + 8'd1;
    sd = 8'h00; se = 1'b0; pe = 1'b0; taken = 1'b0; undef = 1'b0;
    na = cpu_regs.a; nx = cpu_regs.x; ny = cpu_regs.y; ns = cpu_regs.s; np = cpu_regs.p;
    if (cc == 2'd0) begin
      if (bbb == 3'd4) begin
        case (aaa[2:1])
          2'd0: flag_set = np[7];
          2'd1: flag_set = np[6];
          2'd2: flag_set = np[0];
          default: flag_set = np[1];
        endcase
        taken = (flag_set == aaa[0]);
      end else if (bbb == 3'd6) begin
        case (aaa)
          3'd0: np[0] = 1'b0;
          3'd1: np[0] = 1'b1;
          3'd2: np[2] = 1'b0;
          3'd3: np[2] = 1'b1;
          3'd4: begin na = ny; upd_zn(na); end
          3'd5: np[6] = 1'b0;
          3'd6: np[3] = 1'b0;
          default: np[3] = 1'b1;
        endcase
      end else if (bbb == 3'd2) begin
        case (aaa)
          3'd0: begin sd = np | 8'h30; pe = 1'b1; ns = ns - 8'd1; end
          3'd1: begin ns = ns + 8'd1; np = m | 8'h20; end
          3'd2: begin sd = na; pe = 1'b1; ns = ns - 8'd1; end
          3'd3: begin ns = ns + 8'd1; na = m; upd_zn(na); end
          3'd4: begin ny = ny - 8'd1; upd_zn(ny); end
          3'd5: begin ny = na; upd_zn(ny); end
          3'd6: begin ny = ny + 8'd1; upd_zn(ny); end
          default: begin nx = nx + 8'd1; upd_zn(nx); end
        endcase
      end else if (aaa == 3'd5) begin
        ny = m; upd_zn(ny);
      end else if (aaa >= 3'd6) begin
        if (bbb <= 3'd3) compare(aaa == 3'd6 ? ny : nx, m);
      end else if (aaa == 3'd4) begin
        if (bbb == 3'd7) begin sd = ny & h1; se = 1'b1; end
        else if (bbb != 3'd0) begin sd = ny; se = 1'b1; end
      end else if (aaa == 3'd1) begin
        if (bbb == 3'd1 || bbb == 3'd3)
          np = (np & 8'h3D) | (m & 8'hC0) | (((m & na) == 8'h00) ? 8'h02 : 8'h00);
      end else if (bbb == 3'd0 || (bbb == 3'd3 && aaa >= 3'd2)) begin
        undef = 1'b1;
      end
    end else if (cc == 2'd1) begin
      if (aaa == 3'd4) begin
        if (bbb != 3'd2) begin sd = na; se = 1'b1; end
      end else begin
        case (aaa)
          3'd0: begin na = na | m; upd_zn(na); end
          3'd1: begin na = na & m; upd_zn(na); end
          3'd2: begin na = na ^ m; upd_zn(na); end
          3'd3: add_carry(m);
          3'd5: begin na = m; upd_zn(na); end
          3'd6: compare(na, m);
          default: add_carry(~m);
        endcase
      end
    end else if (cc == 2'd2) begin
      if (bbb == 3'd4 || (bbb == 3'd0 && aaa < 3'd4)) begin
        undef = 1'b1;
      end else if (bbb == 3'd0) begin
        if (aaa == 3'd5) begin nx = m; upd_zn(nx); end
      end else if (bbb == 3'd6) begin
        if (aaa == 3'd4) ns = nx;
        else if (aaa == 3'd5) begin nx = ns; upd_zn(nx); end
      end else if (bbb == 3'd2) begin
        case (aaa)
          3'd4: begin na = nx; upd_zn(na); end
          3'd5: begin nx = na; upd_zn(nx); end
          3'd6: begin nx = nx - 8'd1; upd_zn(nx); end
          3'd7: ;
          default: begin na = shift_rot(aaa, na); upd_zn(na); end
        endcase
      end else begin
        case (aaa)
          3'd4: begin sd = (bbb == 3'd7) ? (nx & h1) : nx; se = 1'b1; end
          3'd5: begin nx = m; upd_zn(nx); end
          3'd6: begin r = m - 8'd1; upd_zn(r); sd = r; se = 1'b1; end
          3'd7: begin r = m + 8'd1; upd_zn(r); sd = r; se = 1'b1; end
          default: begin r = shift_rot(aaa, m); upd_zn(r); sd = r; se = 1'b1; end
        endcase
      end
    end else begin
      if (aaa < 3'd4 && bbb == 3'd2) begin
        if (aaa < 3'd2) begin
          na = na & m; upd_zn(na); np[0] = na[7];
        end else if (aaa == 3'd2) begin
          r = na & m; np[0] = r[0]; na = r >> 1; upd_zn(na);
        end else begin
          r = na & m;
          na = {np[0], r[7:1]};
          upd_zn(na);
          np[0] = na[6];
          np[6] = na[6] ^ na[5];
        end
      end else if (aaa < 3'd4) begin
        r = shift_rot(aaa, m); sd = r; se = 1'b1;
        case (aaa)
          3'd0: begin na = na | r; upd_zn(na); end
          3'd1: begin na = na & r; upd_zn(na); end
          3'd2: begin na = na ^ r; upd_zn(na); end
          default: add_carry(r);
        endcase
      end else if (aaa == 3'd4) begin
        if (bbb == 3'd2) begin na = (na | ANE_MAGIC) & nx & m; upd_zn(na); end
        else if (bbb == 3'd4 || bbb == 3'd7) begin sd = na & nx & h1; se = 1'b1; end
        else if (bbb == 3'd6) begin ns = na & nx; sd = ns & h1; se = 1'b1; end
        else begin sd = na & nx; se = 1'b1; end
      end else if (aaa == 3'd5) begin
        if (bbb == 3'd2) na = (na | ANE_MAGIC) & m;
        else if (bbb == 3'd6) begin ns = ns & m; na = ns; end
        else na = m;
        nx = na; upd_zn(na);
      end else if (aaa == 3'd6) begin
        if (bbb == 3'd2) begin
          r = na & nx; np[0] = (r >= m); nx = r - m; upd_zn(nx);
        end else begin
          r = m - 8'd1; sd = r; se = 1'b1; compare(na, r);
        end
      end else begin
        if (bbb == 3'd2) add_carry(~m);
        else begin r = m + 8'd1; sd = r; se = 1'b1; add_carry(~r); end
      end
    end
    // Undefined and jam opcodes leave every register alone.
    if (undef) begin
      sd = 8'h00; se = 1'b0; pe = 1'b0; taken = 1'b0;
    end else begin
      cpu_regs = '{a: na, x: nx, y: ny, s: ns, p: np};
    end
    o.store_data    = sd;
    o.store_enable  = se;
    o.push_enable   = pe;
    o.accumulator   = cpu_regs.a;
    o.index_x       = cpu_regs.x;
    o.index_y       = cpu_regs.y;
    o.stack_pointer = cpu_regs.s;
    o.status_flags  = cpu_regs.p;
    o.branch_taken  = taken;
    o.branch_target = w.next_pc + {{8{m[7]}}, m};
    o.undefined_op  = undef;
    return o;
  endfunction

  // Send one word; the sender may idle first. Prediction happens at accept.
  // Valid stays high after the accept so words can follow back to back.
  task automatic send_word(logic [7:0] func, logic [7:0] operand,
                           logic [7:0] addr_high, logic [15:0] pc);
    in_word_t w;
    w = '{func: func, operand: operand, address_high: addr_high, next_pc: pc};
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.payload <= w;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_results.push_back(execute_opcode(w));
    @(negedge clk);
  endtask

  task automatic send_random(logic [7:0] func);
    send_word(func, 8'($urandom_range(255)), 8'($urandom_range(255)),
              16'($urandom_range(65535)));
  endtask

  // Drop valid, then hold off until every predicted word has come back.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Receiver back-pressure and result comparison.
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    out_word_t exp_word;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result word with none expected, got %h", $time, out_ch.payload);
        error_count++;
      end else begin
        exp_word = pending_results.pop_front();
        if (out_ch.payload !== exp_word) begin
          $display("%0t: mismatch expected %p actual %p", $time, exp_word, out_ch.payload);
          error_count++;
        end
      end
    end
  end

  // Watchdog: count cycles without any accepted word.
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Directed: extremes of fields, pushes, pulls, branches, jams, special flags.
  task automatic test_directed();
    send_word(8'hA9, 8'h00, 8'h00, 16'h0000);   // LDA #0 sets Z
    send_word(8'h69, 8'hFF, 8'hFF, 16'hFFFF);   // ADC of FF to zero, no carry out
    send_word(8'h08, 8'h00, 8'h00, 16'h1234);   // PHP, bits 4 and 5 pushed
    send_word(8'h28, 8'hFF, 8'h00, 16'h0000);   // PLP keeps bit 4
    send_word(8'h28, 8'h00, 8'h00, 16'h0000);
    send_word(8'hA9, 8'h80, 8'h00, 16'h0000);
    send_word(8'h48, 8'h00, 8'h00, 16'h0000);   // PHA
    send_word(8'h68, 8'h7F, 8'h00, 16'h0000);   // PLA
    send_word(8'h9A, 8'h00, 8'h00, 16'h0000);   // TXS to 0, then wrap
    send_word(8'h68, 8'h01, 8'h00, 16'h0000);
    send_word(8'h08, 8'h00, 8'h00, 16'h0000);
    send_word(8'h08, 8'h00, 8'h00, 16'h0000);
    send_word(8'hF0, 8'h80, 8'h00, 16'h0010);   // BEQ backwards, target wraps
    send_word(8'hD0, 8'h7F, 8'h00, 16'hFFF0);
    send_word(8'h02, 8'h55, 8'h00, 16'h0000);   // jam
    send_word(8'h4C, 8'h55, 8'h00, 16'h0000);   // control handled elsewhere
    send_word(8'hA2, 8'hFF, 8'h00, 16'h0000);
    send_word(8'hCB, 8'h01, 8'h00, 16'h0000);   // SBX, N/Z from new X
    send_word(8'hA9, 8'hC0, 8'h00, 16'h0000);
    send_word(8'h38, 8'h00, 8'h00, 16'h0000);
    send_word(8'h6B, 8'hFF, 8'h00, 16'h0000);   // ARR
    send_word(8'h06, 8'h81, 8'h00, 16'h0000);   // zero page RMW stores
    send_word(8'h16, 8'h01, 8'h00, 16'h0000);   // zero page indexed RMW
    send_word(8'h9F, 8'h00, 8'hFF, 16'h0000);   // SHA, address_high wraps
    send_word(8'hF8, 8'h00, 8'h00, 16'h0000);   // SED, no effect on ADC
  endtask

  // Random opcodes over the whole space with random operands.
  task automatic test_random(int count);
    for (int i = 0; i < count; i++) send_random(8'($urandom_range(255)));
  endtask

  initial begin
    error_count = 0;
    send_idle_pct = 18;
    recv_idle_pct = 75;
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.payload = '0;
    out_ch.ready = 1'b0;
    cpu_regs = '{a: 8'h00, x: 8'h00, y: 8'h00, s: SP_RESET, p: FLAG_RESET};
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed();
    test_random(280);
    wait_drained();
    send_idle_pct = 75;
    recv_idle_pct = 18;
    test_random(300);
    wait_drained();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(300);

    wait_drained();
    repeat (8) @(negedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
